@@ rtl/core/scba_pkg.sv @@
// shared constants, types and helpers of the size class block allocator
package scba_pkg;

    localparam int NUM_CLASSES   = 4;
    localparam int MAX_BLOCKS    = 256;
    localparam int MIN_BLOCK     = 8;
    localparam int DEFAULT_COUNT = 16;

    localparam int CLS_W      = 2;
    localparam int BLK_W      = 8;
    localparam int CNT_W      = 9;
    localparam int SIZE_W     = 13;
    localparam int REQ_W      = 16;
    localparam int ADDR_W     = 22;
    localparam int REG_W      = 21;
    localparam int BASE_W     = 23;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam int STEP_W     = $clog2(BLK_W);

    localparam int LINK_AW    = CLS_W + BLK_W;
    localparam int LINK_DEPTH = NUM_CLASSES * MAX_BLOCKS;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNED = 3'd4;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register index map
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FIRST  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_FIRST = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END         = 4'd8;

    // effective per class configuration
    typedef struct packed {
        logic [NUM_CLASSES-1:0][SIZE_W-1:0] size;
        logic [NUM_CLASSES-1:0][CNT_W-1:0]  count;
        logic [NUM_CLASSES-1:0][REG_W-1:0]  region;
        logic [NUM_CLASSES-1:0][BASE_W-1:0] base;
    } class_cfg_t;

    // classified command between front and back
    typedef struct packed {
        logic                is_free;
        logic [CLS_W-1:0]    cls;
        logic [STATUS_W-1:0] status;
        logic [REG_W-1:0]    offset;
    } cmd_t;

    // block size after reset for class c
    function automatic logic [SIZE_W-1:0] reset_size(input int c);
        logic [SIZE_W-1:0] s;
        s = (c < 4) ? SIZE_W'(16 << (2 * c)) : SIZE_W'(4096);
        return s;
    endfunction

endpackage

@@ rtl/core/scba_if.sv @@
// request and response channel interfaces
interface scba_in_if
    import scba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] block_address;

    modport source(output valid, func, request_size, block_address, input ready);
    modport sink(input valid, func, request_size, block_address, output ready);
endinterface

interface scba_out_if
    import scba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
    logic [CLS_W-1:0]    class_index;
    logic [CNT_W-1:0]    free_left;

    modport source(output valid, status, granted_address, class_index, free_left,
                   input ready);
    modport sink(input valid, status, granted_address, class_index, free_left,
                 output ready);
endinterface

@@ rtl/core/scba_front.sv @@
// front end: accepts requests and picks the class and region offset
module scba_front
    import scba_pkg::*;
(
    scba_in_if.sink    req,
    input  class_cfg_t cfg,
    input  logic       hold,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_cmd
);

    logic [BASE_W-1:0] addr_ext;
    logic [BASE_W-1:0] off;

    // transfer only when the queue has room and no clearing pass runs
    assign req.ready  = push_ready & ~hold;
    assign push_valid = req.valid & ~hold;
    assign addr_ext   = BASE_W'(req.block_address);

    // classify the request
    always_comb
    begin
        push_cmd         = '0;
        push_cmd.is_free = req.func;
        off              = '0;
        if (req.func == OP_ALLOC)
        begin
            if (req.request_size == '0)
            begin
                push_cmd.status = ST_ZERO_SIZE;
            end
            else
            begin
                push_cmd.status = ST_NO_FIT;
                // descending scan so the lowest fitting class wins
                for (int c = NUM_CLASSES - 1; c >= 0; c--)
                begin
                    if (REQ_W'(cfg.size[c]) >= req.request_size)
                    begin
                        push_cmd.status = ST_OK;
                        push_cmd.cls    = CLS_W'(c);
                    end
                end
            end
        end
        else
        begin
            push_cmd.status = ST_NOT_OWNED;
            for (int c = NUM_CLASSES - 1; c >= 0; c--)
            begin
                off = addr_ext - cfg.base[c];
                if ((addr_ext >= cfg.base[c]) && (off < BASE_W'(cfg.region[c])))
                begin
                    push_cmd.status = ST_OK;
                    push_cmd.cls    = CLS_W'(c);
                    push_cmd.offset = off[REG_W-1:0];
                end
            end
        end
    end

endmodule

@@ rtl/core/scba_queue.sv @@
// short command queue between front and back
module scba_queue
    import scba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/scba_back.sv @@
// back end: free lists, link memory, block divider and result register
module scba_back
    import scba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rebuild,
    input  class_cfg_t cfg,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  cmd_t       pop_cmd,
    output logic       clearing,
    scba_out_if.source rsp
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    logic [2:0]                         state_reg;
    logic [LINK_AW-1:0]                 clr_cnt_reg;
    logic [NUM_CLASSES-1:0][BLK_W-1:0]  head_reg;
    logic [NUM_CLASSES-1:0][CNT_W-1:0]  free_reg;
    logic [CLS_W-1:0]                   cls_reg;
    logic [BLK_W-1:0]                   blk_reg;
    logic [REG_W-1:0]                   rem_reg;
    logic [BLK_W-1:0]                   quo_reg;
    logic [STEP_W-1:0]                  step_reg;
    logic [REG_W-1:0]                   prod_reg;
    logic                               out_valid_reg;
    logic [STATUS_W-1:0]                status_reg;
    logic [ADDR_W-1:0]                  addr_reg;
    logic [CLS_W-1:0]                   ocls_reg;
    logic [CNT_W-1:0]                   left_reg;

    logic [BLK_W-1:0]   link_mem [LINK_DEPTH];
    logic [BLK_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic [LINK_AW-1:0] mem_waddr;
    logic [BLK_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [LINK_AW-1:0] mem_raddr;

    logic               take;
    logic               clr_last;
    logic [REG_W-1:0]   shifted;
    logic               ge;
    logic [REG_W-1:0]   rem_step;
    logic [BLK_W-1:0]   quo_step;
    logic               div_last;
    logic               push_ok;
    logic [CNT_W-1:0]   free_inc;

    assign clearing   = (state_reg == S_CLEAR);
    assign clr_last   = (clr_cnt_reg == LINK_AW'(LINK_DEPTH - 1));
    assign take       = (state_reg == S_IDLE) && pop_valid && !out_valid_reg;
    assign pop_ready  = take;

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.granted_address = addr_reg;
    assign rsp.class_index     = ocls_reg;
    assign rsp.free_left       = left_reg;

    // one restoring division step per cycle
    assign shifted  = REG_W'(cfg.size[cls_reg]) << step_reg;
    assign ge       = (rem_reg >= shifted);
    assign rem_step = ge ? (rem_reg - shifted) : rem_reg;
    assign quo_step = quo_reg | (BLK_W'(ge) << step_reg);
    assign div_last = (step_reg == '0);
    assign push_ok  = (state_reg == S_DIV) && div_last && (rem_step == '0);
    assign free_inc = (free_reg[cls_reg] < cfg.count[cls_reg]) ?
                      free_reg[cls_reg] + 1'b1 : free_reg[cls_reg];

    // link memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = clr_cnt_reg[BLK_W-1:0] + 1'b1;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (push_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = {cls_reg, quo_step};
            mem_wdata = head_reg[cls_reg];
        end
        mem_re    = take && !pop_cmd.is_free && (pop_cmd.status == ST_OK);
        mem_raddr = {pop_cmd.cls, head_reg[pop_cmd.cls]};
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
            cls_reg       <= '0;
            blk_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            prod_reg      <= '0;
            status_reg    <= ST_OK;
            addr_reg      <= '0;
            ocls_reg      <= '0;
            left_reg      <= '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (rebuild)
            begin
                state_reg   <= S_CLEAR;
                clr_cnt_reg <= '0;
                head_reg    <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                        if (clr_last)
                        begin
                            free_reg  <= cfg.count;
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (take)
                        begin
                            cls_reg <= pop_cmd.cls;
                            blk_reg <= head_reg[pop_cmd.cls];
                            if (pop_cmd.status != ST_OK)
                            begin
                                out_valid_reg <= 1'b1;
                                status_reg    <= pop_cmd.status;
                                addr_reg      <= '0;
                                ocls_reg      <= '0;
                                left_reg      <= '0;
                            end
                            else if (pop_cmd.is_free)
                            begin
                                rem_reg   <= pop_cmd.offset;
                                quo_reg   <= '0;
                                step_reg  <= STEP_W'(BLK_W - 1);
                                state_reg <= S_DIV;
                            end
                            else if (free_reg[pop_cmd.cls] == '0)
                            begin
                                out_valid_reg <= 1'b1;
                                status_reg    <= ST_EXHAUSTED;
                                addr_reg      <= '0;
                                ocls_reg      <= '0;
                                left_reg      <= '0;
                            end
                            else
                            begin
                                state_reg <= S_READ;
                            end
                        end
                    end
                    S_READ:
                    begin
                        head_reg[cls_reg] <= rd_data_reg;
                        free_reg[cls_reg] <= free_reg[cls_reg] - 1'b1;
                        prod_reg  <= REG_W'(blk_reg) * REG_W'(cfg.size[cls_reg]);
                        state_reg <= S_ADDR;
                    end
                    S_ADDR:
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_OK;
                        addr_reg      <= ADDR_W'(cfg.base[cls_reg] + BASE_W'(prod_reg));
                        ocls_reg      <= cls_reg;
                        left_reg      <= free_reg[cls_reg];
                        state_reg     <= S_IDLE;
                    end
                    S_DIV:
                    begin
                        rem_reg  <= rem_step;
                        quo_reg  <= quo_step;
                        step_reg <= step_reg - 1'b1;
                        if (div_last)
                        begin
                            out_valid_reg <= 1'b1;
                            addr_reg      <= '0;
                            state_reg     <= S_IDLE;
                            if (push_ok)
                            begin
                                head_reg[cls_reg] <= quo_step;
                                free_reg[cls_reg] <= free_inc;
                                status_reg        <= ST_OK;
                                ocls_reg          <= cls_reg;
                                left_reg          <= free_inc;
                            end
                            else
                            begin
                                status_reg <= ST_NOT_OWNED;
                                ocls_reg   <= '0;
                                left_reg   <= '0;
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= S_CLEAR;
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/core/size_class_block_allocator.sv @@
// top level of the size class block allocator
// Four size classes, each a LIFO free list of equal blocks laid out one
// region after another from offset zero. A request is classified in the
// front end in its transfer cycle and queued; the back end then serves one
// command at a time. Errors found at classification and an exhausted class
// answer from the result register once the back end takes the command; an
// allocate goes through link memory read, then block index times size,
// then base add; a free goes through the eight-step divider that turns the
// region offset into a block index and checks alignment. After reset and
// after any write to a size or count register, a clearing pass rebuilds the
// link memory one entry per cycle; no request transfer is taken during that
// pass, while register writes still are.
module size_class_block_allocator
    import scba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    scba_in_if.sink               req,
    scba_out_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [NUM_CLASSES-1:0][SIZE_W-1:0] size_reg;
    logic [NUM_CLASSES-1:0][CNT_W-1:0]  count_reg;
    logic [NUM_CLASSES-1:0][SIZE_W-1:0] size_eff;
    logic [NUM_CLASSES-1:0][CNT_W-1:0]  count_eff;
    logic [NUM_CLASSES-1:0][REG_W-1:0]  region_reg;
    logic [NUM_CLASSES-1:0][BASE_W-1:0] base_reg;
    logic [NUM_CLASSES-1:0][BASE_W-1:0] base_next;
    logic [CFG_IDX_W-1:0]               count_slot;
    logic                               size_hit;
    logic                               count_hit;
    logic                               rebuild;
    class_cfg_t                         cfg;
    logic                               clearing;
    logic                               push_valid;
    logic                               push_ready;
    cmd_t                               push_cmd;
    logic                               pop_valid;
    logic                               pop_ready;
    cmd_t                               pop_cmd;

    // register decode
    assign count_slot = cfg_index - CFG_COUNT_FIRST;
    assign size_hit   = (cfg_index >= CFG_SIZE_FIRST) && (cfg_index < CFG_COUNT_FIRST) &&
                        ((cfg_index - CFG_SIZE_FIRST) < CFG_IDX_W'(NUM_CLASSES));
    assign count_hit  = (cfg_index >= CFG_COUNT_FIRST) && (cfg_index < CFG_END) &&
                        (count_slot < CFG_IDX_W'(NUM_CLASSES));
    assign rebuild    = cfg_we && (size_hit || count_hit);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                size_reg[c]  <= reset_size(c);
                count_reg[c] <= CNT_W'(DEFAULT_COUNT);
            end
        end
        else if (cfg_we)
        begin
            if (size_hit)
            begin
                size_reg[cfg_index[CLS_W-1:0]] <= cfg_data;
            end
            if (count_hit)
            begin
                count_reg[count_slot[CLS_W-1:0]] <= cfg_data[CNT_W-1:0];
            end
        end
    end

    // effective size and count
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            size_eff[c] = (size_reg[c] < SIZE_W'(MIN_BLOCK)) ? SIZE_W'(MIN_BLOCK) : size_reg[c];
            if (count_reg[c] == '0)
            begin
                count_eff[c] = CNT_W'(DEFAULT_COUNT);
            end
            else if (count_reg[c] > CNT_W'(MAX_BLOCKS))
            begin
                count_eff[c] = CNT_W'(MAX_BLOCKS);
            end
            else
            begin
                count_eff[c] = count_reg[c];
            end
        end
    end

    // region bases as running sums of the registered region sizes
    always_comb
    begin
        base_next[0] = '0;
        for (int c = 1; c < NUM_CLASSES; c++)
        begin
            base_next[c] = base_next[c-1] + BASE_W'(region_reg[c-1]);
        end
    end

    // region sizes and bases settle well inside the clearing pass
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            region_reg[c] <= REG_W'(size_eff[c]) * REG_W'(count_eff[c]);
        end
        base_reg <= base_next;
    end

    assign cfg.size   = size_eff;
    assign cfg.count  = count_eff;
    assign cfg.region = region_reg;
    assign cfg.base   = base_reg;

    scba_front u_front (
        .req        (req),
        .cfg        (cfg),
        .hold       (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    scba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    scba_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rebuild   (rebuild),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .clearing  (clearing),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // no request transfer while the link memory is rebuilt
    a_hold_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready)
        else $error("request taken during clearing pass");

    // a write to a size or count register starts a clearing pass
    a_rebuild_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rebuild |=> clearing)
        else $error("register write did not start clearing");

    // failed results carry zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |->
        ((rsp.granted_address == '0) && (rsp.class_index == '0) && (rsp.free_left == '0)))
        else $error("failed result with nonzero payload");
`endif

endmodule
